// ===== rtl/ccb_pkg.sv =====
// ----------------------------------------------------------------------------
// ccb_pkg: shared types and constants for the character class bitmap builder
// Character codes, bitmap geometry and mask helpers used by the parser and
// the top level.
// ----------------------------------------------------------------------------
package ccb_pkg;

  localparam int BITMAP_WORDS = 4;
  localparam int WORD_W       = 64;
  localparam int BITMAP_W     = BITMAP_WORDS * WORD_W;
  localparam int CH_W         = 7;
  localparam int IDX_W        = 2;

  localparam logic [CH_W-1:0] CH_CARET = 7'h5E;
  localparam logic [CH_W-1:0] CH_DASH  = 7'h2D;
  localparam logic [CH_W-1:0] CH_CLOSE = 7'h5D;

  typedef logic [CH_W-1:0]     char_t;
  typedef logic [BITMAP_W-1:0] bitmap_t;
  typedef logic [IDX_W-1:0]    word_idx_t;

  typedef struct packed {
    bitmap_t bits;
    logic    negated;
    logic    bad_range;
  } class_result_t;

  // One-hot set for a single code.
  function automatic bitmap_t code_mask(input char_t code);
    bitmap_t m;
    m = '0;
    m[{1'b0, code}] = 1'b1;
    return m;
  endfunction

  // Inclusive range lo..hi, empty when lo is above hi.
  function automatic bitmap_t range_mask(input char_t lo, input char_t hi);
    bitmap_t m;
    m = '0;
    for (int i = 0; i < BITMAP_W; i++) begin
      m[i] = (i >= int'(lo)) && (i <= int'(hi));
    end
    return m;
  endfunction

endpackage

// ===== rtl/ccb_if.sv =====
// ----------------------------------------------------------------------------
// ccb_if: item channels of the character class bitmap builder
// Character channel into the block and bitmap word channel out of it.
// ----------------------------------------------------------------------------
interface ccb_char_if;
  logic            valid;
  logic            ready;
  ccb_pkg::char_t  ch;
  logic            is_final;

  modport source (output valid, output ch, output is_final, input ready);
  modport sink   (input valid, input ch, input is_final, output ready);
endinterface

interface ccb_word_if;
  logic                        valid;
  logic                        ready;
  ccb_pkg::word_idx_t          word_index;
  logic [ccb_pkg::WORD_W-1:0]  bitmap_word;
  logic                        negated;
  logic                        bad_range;
  logic                        last_word;

  modport source (output valid, output word_index, output bitmap_word, output negated,
                  output bad_range, output last_word, input ready);
  modport sink   (input valid, input word_index, input bitmap_word, input negated,
                  input bad_range, input last_word, output ready);
endinterface

// ===== rtl/ccb_parse.sv =====
// ----------------------------------------------------------------------------
// ccb_parse: bracket expression parser
// Holds the look-ahead window and the member set, folds in one character per
// accepted item and presents the finished class on the final character.
// ----------------------------------------------------------------------------
module ccb_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  ccb_pkg::char_t         ch,
  input  logic                   is_final,
  output ccb_pkg::class_result_t result
);

  ccb_pkg::bitmap_t member, member_next;
  ccb_pkg::char_t   w0, w0_next, w1, w1_next;
  logic [1:0]       fill, fill_next;
  logic             first, neg, neg_next, err, err_next;
  ccb_pkg::bitmap_t flush_add;

  always_comb begin
    member_next = member;
    w0_next     = w0;
    w1_next     = w1;
    fill_next   = fill;
    neg_next    = neg;
    err_next    = err;
    if (first && ch == ccb_pkg::CH_CARET) begin
      neg_next = 1'b1;
    end else if (fill == 2'd2) begin
      if (w1 == ccb_pkg::CH_DASH && ch != ccb_pkg::CH_CLOSE) begin
        if (w0 > ch) begin
          err_next = 1'b1;
        end else begin
          member_next = member | ccb_pkg::range_mask(w0, ch);
        end
        fill_next = 2'd0;
      end else begin
        member_next = member | ccb_pkg::code_mask(w0);
        w0_next     = w1;
        w1_next     = ch;
      end
    end else if (fill == 2'd1) begin
      w1_next   = ch;
      fill_next = 2'd2;
    end else begin
      w0_next   = ch;
      fill_next = 2'd1;
    end

    // drain the window on the final character
    flush_add = '0;
    if (fill_next == 2'd1 && w0_next != ccb_pkg::CH_CLOSE) begin
      flush_add = ccb_pkg::code_mask(w0_next);
    end else if (fill_next == 2'd2) begin
      flush_add = ccb_pkg::code_mask(w0_next);
      if (w1_next != ccb_pkg::CH_CLOSE) begin
        flush_add = flush_add | ccb_pkg::code_mask(w1_next);
      end
    end

    result.bits      = err_next ? '0 : (member_next | flush_add);
    result.negated   = neg_next;
    result.bad_range = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      member <= '0;
      w0     <= '0;
      w1     <= '0;
      fill   <= 2'd0;
      first  <= 1'b1;
      neg    <= 1'b0;
      err    <= 1'b0;
    end else if (accept) begin
      if (is_final) begin
        member <= '0;
        w0     <= '0;
        w1     <= '0;
        fill   <= 2'd0;
        first  <= 1'b1;
        neg    <= 1'b0;
        err    <= 1'b0;
      end else begin
        member <= member_next;
        w0     <= w0_next;
        w1     <= w1_next;
        fill   <= fill_next;
        first  <= 1'b0;
        neg    <= neg_next;
        err    <= err_next;
      end
    end
  end

endmodule

// ===== rtl/char_class_to_bitmap.sv =====
// ----------------------------------------------------------------------------
// char_class_to_bitmap: regex character class to membership bitmap
// Parses a bracket expression body and emits its 256-bit set as 64-bit words.
//
//   channel  role  payload
//   chars    sink  ch, is_final
//   words    src   word_index, bitmap_word, negated, bad_range, last_word
//
// One character is taken per cycle; the final character yields BITMAP_WORDS
// words on the following cycles, one per cycle while words.ready is high.
// Non-final characters of the next class are taken while words drain; a final
// character waits only until the previous class's last word leaves.
// Synchronous reset clears the parser and empties the word buffer.
// ----------------------------------------------------------------------------
module char_class_to_bitmap (
  input  logic          clk,
  input  logic          rst,
  ccb_char_if.sink      chars,
  ccb_word_if.source    words
);

  ccb_pkg::class_result_t result;
  ccb_pkg::bitmap_t       obuf;
  logic                   oneg, oerr, busy;
  ccb_pkg::word_idx_t     idx;
  logic                   accept, take, last, drain_done;

  assign last       = idx == ccb_pkg::IDX_W'(ccb_pkg::BITMAP_WORDS - 1);
  assign take       = busy && words.ready;
  assign drain_done = take && last;
  assign chars.ready = !(chars.is_final && busy && !drain_done);
  assign accept     = chars.valid && chars.ready;

  ccb_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .ch       (chars.ch),
    .is_final (chars.is_final),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (accept && chars.is_final) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (last) begin
        busy <= 1'b0;
      end
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && chars.is_final) begin
      obuf <= result.bits;
      oneg <= result.negated;
      oerr <= result.bad_range;
    end
  end

  assign words.valid       = busy;
  assign words.word_index  = idx;
  assign words.bitmap_word = obuf[{idx, 6'd0} +: ccb_pkg::WORD_W];
  assign words.negated     = oneg;
  assign words.bad_range   = oerr;
  assign words.last_word   = last;

endmodule

// ===== bench/char_class_to_bitmap_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_class_to_bitmap_test: self-checking bench for the class bitmap builder
// Sends bracket-expression bodies over the character channel and checks
// every emitted bitmap word against a model of the parser. The run starts
// with hand-picked classes: caret handling, ranges, a reversed range, a
// bracket at the end and the 1..127 extremes. It then sends random classes,
// mostly well formed and some noise. Both channels idle at random.
// ----------------------------------------------------------------------------
module char_class_to_bitmap_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    ccb_pkg::char_t ch;
    logic           fin;
  } class_char_t;

  typedef struct packed {
    ccb_pkg::word_idx_t         idx;
    logic [ccb_pkg::WORD_W-1:0] bits;
    logic                       neg;
    logic                       bad;
    logic                       last;
  } bitmap_word_t;

  logic clk = 1'b0;
  logic rst;

  ccb_char_if char_bus ();
  ccb_word_if word_bus ();

  char_class_to_bitmap dut (
    .clk   (clk),
    .rst   (rst),
    .chars (char_bus),
    .words (word_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  class_char_t  pending_chars[$];
  bitmap_word_t expected_words[$];

  // parser model state
  ccb_pkg::bitmap_t class_bits      = '0;
  ccb_pkg::char_t   peek_chars[2]   = '{default: '0};
  int               peek_count      = 0;
  logic             at_class_start  = 1'b1;
  logic             class_negated   = 1'b0;
  logic             class_bad_range = 1'b0;

  int classes_done   = 0;
  int negated_seen   = 0;
  int reversed_seen  = 0;
  int chars_accepted = 0;
  int words_checked  = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int calm_left      = 0;
  int send_gap       = 0;
  int recv_stall     = 0;

  class_char_t  next_char;
  bitmap_word_t want;
  bitmap_word_t got;

  function automatic void mark_code(ccb_pkg::char_t c);
    class_bits[{1'b0, c}] = 1'b1;
  endfunction

  function automatic void take_char(ccb_pkg::char_t c, logic fin);
    ccb_pkg::char_t w0;
    ccb_pkg::char_t w1;
    bitmap_word_t   word;
    w0 = peek_chars[0];
    w1 = peek_chars[1];
    chars_accepted++;
    if (at_class_start && c == ccb_pkg::CH_CARET) begin
      class_negated = 1'b1;
    end else if (peek_count < 2) begin
      peek_chars[peek_count] = c;
      peek_count++;
    end else if (w1 == ccb_pkg::CH_DASH && c != ccb_pkg::CH_CLOSE) begin
      if (w0 > c) begin
        class_bad_range = 1'b1;
      end else begin
        for (int i = int'(w0); i <= int'(c); i++) class_bits[i] = 1'b1;
      end
      peek_count = 0;
    end else begin
      mark_code(w0);
      peek_chars[0] = w1;
      peek_chars[1] = c;
    end
    at_class_start = 1'b0;
    if (!fin) return;

    // flush the window; a closing bracket at the very end is dropped
    for (int k = 0; k < peek_count; k++) begin
      if (!(k == peek_count - 1 && peek_chars[k] == ccb_pkg::CH_CLOSE))
        mark_code(peek_chars[k]);
    end
    for (int w = 0; w < ccb_pkg::BITMAP_WORDS; w++) begin
      word.idx  = ccb_pkg::word_idx_t'(w);
      word.bits = class_bad_range ? '0 : class_bits[w*ccb_pkg::WORD_W +: ccb_pkg::WORD_W];
      word.neg  = class_negated;
      word.bad  = class_bad_range;
      word.last = (w == ccb_pkg::BITMAP_WORDS - 1);
      expected_words.push_back(word);
    end
    classes_done++;
    negated_seen  += class_negated;
    reversed_seen += class_bad_range;
    class_bits      = '0;
    peek_chars      = '{default: '0};
    peek_count      = 0;
    at_class_start  = 1'b1;
    class_negated   = 1'b0;
    class_bad_range = 1'b0;
  endfunction

  // mostly back-to-back or short gaps, a few long ones, now and then a calm stretch
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic ccb_pkg::char_t pick_char();
    case ($urandom_range(0, 9))
      0: return ccb_pkg::CH_CARET;
      1: return ccb_pkg::CH_DASH;
      2: return ccb_pkg::CH_CLOSE;
      default: return ccb_pkg::char_t'($urandom_range(1, 127));
    endcase
  endfunction

  task automatic queue_code(ccb_pkg::char_t c, logic fin);
    class_char_t item;
    item.ch  = c;
    item.fin = fin;
    pending_chars.push_back(item);
  endtask

  task automatic queue_class(string s);
    for (int i = 0; i < s.len(); i++)
      queue_code(ccb_pkg::char_t'(s[i]), i == s.len() - 1);
  endtask

  // character driver
  always @(posedge clk) begin
    if (rst) begin
      char_bus.valid <= 1'b0;
      send_gap       <= 0;
    end else begin
      if (char_bus.valid && char_bus.ready) take_char(char_bus.ch, char_bus.is_final);
      if (!char_bus.valid || char_bus.ready) begin
        if (send_gap > 0) begin
          send_gap       <= send_gap - 1;
          char_bus.valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          next_char         = pending_chars.pop_front();
          char_bus.valid    <= 1'b1;
          char_bus.ch       <= next_char.ch;
          char_bus.is_final <= next_char.fin;
          send_gap          <= pick_gap();
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  // word monitor
  always @(posedge clk) begin
    if (rst) begin
      word_bus.ready <= 1'b0;
      recv_stall     <= 0;
    end else begin
      if (word_bus.valid && word_bus.ready) begin
        got.idx  = word_bus.word_index;
        got.bits = word_bus.bitmap_word;
        got.neg  = word_bus.negated;
        got.bad  = word_bus.bad_range;
        got.last = word_bus.last_word;
        words_checked++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: index %0d bits %h neg %b bad %b last %b",
                     got.idx, got.bits, got.neg, got.bad, got.last);
        end else begin
          want = expected_words.pop_front();
          if (got.idx !== want.idx || got.bits !== want.bits || got.neg !== want.neg ||
              got.bad !== want.bad || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word mismatch: expected index %0d bits %h neg %b bad %b last %b",
                       want.idx, want.bits, want.neg, want.bad, want.last);
              $display("                 actual index %0d bits %h neg %b bad %b last %b",
                       got.idx, got.bits, got.neg, got.bad, got.last);
            end
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall     <= recv_stall - 1;
        word_bus.ready <= 1'b0;
      end else begin
        word_bus.ready <= 1'b1;
        recv_stall     <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int random_chars;
    int mark;
    int lo;
    int hi;
    rst               = 1'b1;
    char_bus.valid    = 1'b0;
    char_bus.ch       = '0;
    char_bus.is_final = 1'b0;
    word_bus.ready    = 1'b0;

    queue_class("^");
    queue_class("a-z");
    queue_class("^]");
    queue_class("z-a");
    queue_class("a-]");
    queue_class("x^");
    queue_class("]");
    queue_class("]a");
    queue_code(ccb_pkg::char_t'(1), 1'b0);
    queue_code(ccb_pkg::CH_DASH, 1'b0);
    queue_code(ccb_pkg::char_t'(127), 1'b1);
    queue_code(ccb_pkg::char_t'(127), 1'b1);

    random_chars = 0;
    while (random_chars < 80) begin
      mark = pending_chars.size();
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) == 0) queue_code(ccb_pkg::CH_CARET, 1'b0);
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              if ($urandom_range(0, 7) == 0) begin
                lo = $urandom_range(2, 127);
                hi = $urandom_range(1, lo - 1);
              end else begin
                lo = $urandom_range(1, 127);
                hi = $urandom_range(lo, 127);
              end
              queue_code(ccb_pkg::char_t'(lo), 1'b0);
              queue_code(ccb_pkg::CH_DASH, 1'b0);
              queue_code(ccb_pkg::char_t'(hi), 1'b0);
            end
            4, 5, 6, 7, 8: queue_code(pick_char(), 1'b0);
            default: queue_code(ccb_pkg::CH_CLOSE, 1'b0);
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 6))
          queue_code(ccb_pkg::char_t'($urandom_range(1, 127)), 1'b0);
      end
      pending_chars[pending_chars.size() - 1].fin = 1'b1;
      random_chars += pending_chars.size() - mark;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() > 0 || char_bus.valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d characters in %0d classes, checked %0d bitmap words",
             chars_accepted, classes_done, words_checked);
    $display("classes negated: %0d, with a reversed range: %0d",
             negated_seen, reversed_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatched words", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
